// ===== hdl/bdq_pkg.sv =====
// bounded deque package: command codes and field widths
package bdq_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 10;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_READ_FRONT = 3'd4,
      CMD_READ_BACK  = 3'd5,
      CMD_READ_INDEX = 3'd6
   } cmd_type;

endpackage

// ===== hdl/bdq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bounded_deque_top.sv =====
// bounded deque top level: command decode, ring pointers, ram and result stage
//
// A double-ended queue of signed 32-bit words held in one ring ram of DEPTH
// entries. Each request transaction carries a command in req_tuser and the
// word and index in req_tdata. Pushes and pops give no response; the three
// read commands give exactly one response transaction each, with the word
// in rsp_tdata and the found flag in rsp_tuser.
// One command is accepted per cycle while req_tready is high. A read's
// response passes through the registered read port of the ring ram and
// then the output register before it is presented.
// Every command does at most a single ram access, a write or a read, so back-to-back
// commands see each other's pointer updates without any stall.
// A response that waits for rsp_tready sits in the output register; a second
// read can wait behind it in the ram read stage, after which req_tready drops
// until the response side moves again.
// Reset empties the queue (head and count to zero) and drops any pending
// response; the ram contents are not cleared and need no clearing pass.
module bounded_deque_top
   import bdq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // value [31:0], index [41:32], zero pad
   input  logic [CMD_W-1:0]       req_tuser,  // cmd [2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // data [31:0]
   output logic                   rsp_tuser   // found [0]
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (PW > INDEX_W) ? PW : INDEX_W;
   localparam int MW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          s1_vld_ff, s1_vld_in;
   logic          s1_found_ff, s1_found_in;
   logic          out_vld_ff, out_vld_in;
   logic [VALUE_W-1:0] out_data_ff;
   logic          out_found_ff;

   cmd_type            cmd;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] index;
   logic [IW-1:0]      index_wide;
   logic [PW-1:0]      offset;
   logic [PW:0]        addr_sum;
   logic [PW-1:0]      addr;
   logic [PW-1:0]      head_dec;
   logic [PW-1:0]      head_inc;
   logic               accept;
   logic               out_free;
   logic               not_full;
   logic               not_empty;
   logic               wr_en;
   logic               rd_en;
   logic               hit;
   logic [VALUE_W-1:0] ram_q;

   assign cmd        = cmd_type'(req_tuser);
   assign value      = req_tdata[VALUE_W-1:0];
   assign index      = req_tdata[VALUE_W+INDEX_W-1:VALUE_W];
   assign index_wide = IW'(index);

   assign out_free   = !out_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign not_full  = count_ff < CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_dec  = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign head_inc  = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);

   // ring address for the offset from the front
   assign addr_sum = {1'b0, head_ff} + {1'b0, offset};
   assign addr     = (addr_sum >= (PW+1)'(DEPTH)) ?
                     PW'(addr_sum - (PW+1)'(DEPTH)) : addr_sum[PW-1:0];

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      offset      = '0;
      hit         = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      unique case (cmd)
         CMD_PUSH_BACK: begin
            offset = count_ff[PW-1:0];
            if (accept && not_full) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP_BACK: begin
            if (accept && not_empty) begin
               count_in = count_ff - CW'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            offset = PW'(DEPTH - 1);
            if (accept && not_full) begin
               wr_en    = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (accept && not_empty) begin
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_READ_FRONT: begin
            hit   = not_empty;
            rd_en = accept;
         end
         CMD_READ_BACK: begin
            hit    = not_empty;
            offset = PW'(count_ff - CW'(1));
            rd_en  = accept;
         end
         CMD_READ_INDEX: begin
            hit    = MW'(index) < MW'(count_ff);
            offset = index_wide[PW-1:0];
            rd_en  = accept;
         end
         default: begin
         end
      endcase
   end

   // response pipeline: ram read stage then output register
   always_comb begin
      s1_vld_in   = s1_vld_ff;
      s1_found_in = s1_found_ff;
      out_vld_in  = out_vld_ff;
      if (out_free) begin
         out_vld_in = s1_vld_ff;
         s1_vld_in  = 1'b0;
      end
      if (rd_en) begin
         s1_vld_in   = 1'b1;
         s1_found_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_found_ff <= s1_found_in;
      if (out_free && s1_vld_ff) begin
         out_data_ff  <= s1_found_ff ? ram_q : '0;
         out_found_ff <= s1_found_ff;
      end
   end

   bdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (value),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_found_ff;

   // count stays within the ring
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   // a miss always carries a zero word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss response with nonzero data");

   // every accepted read lands in the ram read stage
   assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_vld_ff)
      else $error("read transaction lost");

   // an accepted push on a non-full queue grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      accept && not_full && (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the queue");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the bounded deque: command stream in, read responses checked
`timescale 1ns / 100ps

module tb_top;
   import bdq_pkg::*;

   localparam int DEPTH      = 1024;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 10;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } deque_cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] data;
      logic               found;
   } read_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // value [31:0], index [41:32], zero pad
   logic [CMD_W-1:0]       req_tuser = '0;  // cmd [2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // data [31:0]
   logic                   rsp_tuser;       // found [0]

   bounded_deque_top #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   deque_cmd_type   cmds_pending[$];
   read_result_type reads_due[$];
   int              mismatches = 0;

   // shadow deque state
   logic [VALUE_W-1:0] shadow_ring [0:DEPTH-1];
   int                 shadow_head = 0;
   int                 shadow_count = 0;

   task automatic report_mismatch(input string what, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
   endtask

   task automatic deque_apply(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
      logic            is_read;
      logic            hit;
      int              pos;
      read_result_type res;
      is_read = 1'b0;
      hit = 1'b0;
      pos = 0;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (shadow_count < DEPTH) begin
               shadow_ring[SLOT_W'((shadow_head + shadow_count) % DEPTH)] = value;
               shadow_count++;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count > 0) shadow_count--;
         end
         CMD_PUSH_FRONT: begin
            if (shadow_count < DEPTH) begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_ring[SLOT_W'(shadow_head)] = value;
               shadow_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count > 0) begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
         CMD_READ_FRONT: begin
            is_read = 1'b1;
            hit = shadow_count > 0;
            pos = 0;
         end
         CMD_READ_BACK: begin
            is_read = 1'b1;
            hit = shadow_count > 0;
            pos = hit ? shadow_count - 1 : 0;
         end
         CMD_READ_INDEX: begin
            is_read = 1'b1;
            hit = int'(index) < shadow_count;
            pos = int'(index);
         end
         default: ;
      endcase
      if (is_read) begin
         res.found = hit;
         res.data = hit ? shadow_ring[SLOT_W'((shadow_head + pos) % DEPTH)] : '0;
         reads_due.insert(reads_due.size(), res);
      end
   endtask

   // driver: bursts with random gaps
   deque_cmd_type next_cmd;
   int            burst_left = 8;
   int            gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (cmds_pending.size() > 0) begin
            next_cmd = cmds_pending[0];
            cmds_pending.delete(0);
            req_tvalid <= 1'b1;
            req_tuser <= next_cmd.cmd;
            req_tdata <= {{(REQ_TDATA_W - VALUE_W - INDEX_W){1'b0}}, next_cmd.index,
                          next_cmd.value};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, switching at random between four modes
   int stall_mode = 0;
   int mode_left = 0;
   int phase_bit = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
      phase_bit <= phase_bit ^ 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= phase_bit[0];
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // monitor: check responses, then predict from accepted commands
   read_result_type oldest_due;

   always @(posedge clock) begin
      if (reset) begin
         shadow_head = 0;
         shadow_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reads_due.size() == 0) begin
               report_mismatch("unexpected response, data", 64'sd0,
                               64'($signed(rsp_tdata)));
            end else begin
               oldest_due = reads_due[0];
               reads_due.delete(0);
               if (rsp_tdata !== oldest_due.data)
                  report_mismatch("data", 64'($signed(oldest_due.data)),
                                  64'($signed(rsp_tdata)));
               if (rsp_tuser !== oldest_due.found)
                  report_mismatch("found", 64'(oldest_due.found), 64'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready)
            deque_apply(req_tuser, req_tdata[VALUE_W-1:0], req_tdata[VALUE_W +: INDEX_W]);
      end
   end

   // watchdog on cycles without any transaction
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus generation, tracks the fill level to steer the sequences
   int fill_level = 0;

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
      deque_cmd_type c;
      c.cmd = cmd;
      c.value = value;
      c.index = index;
      cmds_pending.insert(cmds_pending.size(), c);
      if ((cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) && fill_level < DEPTH)
         fill_level++;
      if ((cmd == CMD_POP_BACK || cmd == CMD_POP_FRONT) && fill_level > 0)
         fill_level--;
   endtask

   task automatic queue_random_cmd(input int push_pct, input int pop_pct);
      int                 pick;
      int                 hi;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      hi = (fill_level < DEPTH - 1) ? fill_level + 1 : DEPTH - 1;
      idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, DEPTH - 1)) :
                                          INDEX_W'($urandom_range(0, hi));
      if ($urandom_range(0, 99) == 0)
         queue_cmd(CMD_UNUSED, $urandom, INDEX_W'($urandom));
      else if (pick < push_pct)
         queue_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom, idx);
      else if (pick < push_pct + pop_pct)
         queue_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom, idx);
      else
         case ($urandom_range(0, 2))
            0: queue_cmd(CMD_READ_FRONT, $urandom, idx);
            1: queue_cmd(CMD_READ_BACK, $urandom, idx);
            default: queue_cmd(CMD_READ_INDEX, $urandom, idx);
         endcase
   endtask

   task automatic wait_all_done;
      while (cmds_pending.size() > 0 || req_tvalid || reads_due.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty queue reads and pops, unused code
      queue_cmd(CMD_READ_FRONT, 32'h0, 10'h0);
      queue_cmd(CMD_READ_BACK, 32'h0, 10'h0);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'h0);
      queue_cmd(CMD_POP_BACK, 32'h0, 10'h0);
      queue_cmd(CMD_POP_FRONT, 32'h0, 10'h0);
      queue_cmd(CMD_UNUSED, 32'hffff_ffff, 10'h3ff);
      // extremes of the value field
      queue_cmd(CMD_PUSH_BACK, 32'h7fff_ffff, 10'h0);
      queue_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 10'h3ff);
      queue_cmd(CMD_PUSH_BACK, 32'h0000_0000, 10'h155);
      queue_cmd(CMD_PUSH_FRONT, 32'hffff_ffff, 10'h2aa);
      queue_cmd(CMD_READ_FRONT, 32'h0, 10'h0);
      queue_cmd(CMD_READ_BACK, 32'h0, 10'h0);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'd0);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'd3);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'd4);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'h3ff);
      queue_cmd(CMD_POP_FRONT, 32'h0, 10'h0);
      queue_cmd(CMD_READ_FRONT, 32'h0, 10'h0);
      queue_cmd(CMD_POP_BACK, 32'h0, 10'h0);
      queue_cmd(CMD_READ_BACK, 32'h0, 10'h0);
      queue_cmd(CMD_PUSH_BACK, 32'h5555_5555, 10'h3ff);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'd2);
      queue_cmd(CMD_READ_INDEX, 32'h0, 10'd1);
      wait_all_done();
      // hold off with nothing outstanding
      repeat (DRAIN_WAIT) @(posedge clock);

      repeat (60) queue_random_cmd(40, 25);
      // fill to the top, then inserts on a full queue
      while (fill_level < DEPTH) queue_random_cmd(96, 1);
      queue_cmd(CMD_PUSH_BACK, $urandom, INDEX_W'($urandom));
      queue_cmd(CMD_PUSH_FRONT, $urandom, INDEX_W'($urandom));
      queue_cmd(CMD_READ_INDEX, $urandom, 10'h3ff);
      queue_cmd(CMD_READ_INDEX, $urandom, 10'h3fe);
      queue_cmd(CMD_READ_FRONT, $urandom, INDEX_W'($urandom));
      queue_cmd(CMD_READ_BACK, $urandom, INDEX_W'($urandom));
      repeat (20) queue_random_cmd(60, 5);
      repeat (60) queue_random_cmd(10, 60);
      repeat (40) queue_random_cmd(35, 35);

      wait_all_done();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
